FILE: hw/rtl/supervisory_frame_receiver_top_macros.svh
// Assertion macros shared by the supervisory frame receiver.
`ifndef SUPERVISORY_FRAME_RECEIVER_TOP_MACROS_SVH
`define SUPERVISORY_FRAME_RECEIVER_TOP_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define SFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checks that a condition implies another one on the same edge.
`define SFR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sfr_pkg.sv
// Types, constants and helper functions of the supervisory frame receiver.
`default_nettype none

package sfr_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_FLAG    = 2'd0;
    localparam logic [1:0] REG_ADDRESS = 2'd1;
    localparam logic [1:0] REG_LENGTH  = 2'd2;

    localparam logic [7:0] FLAG_RESET    = 8'h7E;
    localparam logic [7:0] ADDRESS_RESET = 8'h03;
    localparam logic [2:0] LENGTH_RESET  = 3'd5;

    localparam logic [2:0] LENGTH_MIN = 3'd4;
    localparam logic [2:0] LENGTH_MAX = 3'd5;

    localparam logic [1:0] REQ_BYTE    = 2'd0;
    localparam logic [1:0] REQ_TIMEOUT = 2'd1;

    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_NODATA  = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [7:0] CTRL_ZERO = 8'h00;
    localparam logic [7:0] CTRL_TWO  = 8'h02;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_TIMEOUT,
        KIND_ERROR
    } kind_t;

    typedef enum logic [2:0] {
        PS_IDLE,
        PS_FLAG,
        PS_ADDR,
        PS_CTRL,
        PS_BCC,
        PS_CLOSE
    } parse_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } evt_t;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] address_byte;
        logic [2:0] frame_length;
    } cfg_t;

    function automatic logic control_ok(input logic [7:0] c);
        return c[0] || (c == CTRL_ZERO) || (c == CTRL_TWO);
    endfunction

    function automatic logic [2:0] effective_length(input logic [2:0] len);
        logic [2:0] r;
        r = len;
        if (len < LENGTH_MIN) begin
            r = LENGTH_MIN;
        end else if (len > LENGTH_MAX) begin
            r = LENGTH_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/supervisory_frame_receiver_top.sv
// Supervisory frame receiver usage:
// The s_ channel takes one event per transfer: s_tuser carries the request
// kind (received byte, read timeout, link error) and s_tdata the byte.
// The m_ channel delivers at most one result per event: m_tuser carries the
// status and m_tdata the captured control byte, which is zero unless the
// status reports a valid frame.
// A byte that completes a frame, a timeout and a link error each produce a
// result; other bytes only advance the parser.
// An accepted event is queued, popped by the parser, and its result is
// registered before m_tvalid shows it. The block sustains one event per
// cycle unless a result stalls on the m_ side; the rate is set by the
// parser state machine, one event a cycle, behind a two-entry queue.
// A synchronous low aresetn empties the queue, drops any pending result,
// sends the parser to idle, clears the captured control byte and restores
// the flag (0x7E), address (0x03) and frame length (5) registers.
// When the m_ side stalls, the result register holds its transfer, the
// queue fills, and s_tready falls once the queue is full. Registers are to be
// written over the APB-style port only while idle; this is not enforced.
`default_nettype none
`include "supervisory_frame_receiver_top_macros.svh"

module supervisory_frame_receiver_top #(
    parameter int QueueDepth = sfr_pkg::QUEUE_DEPTH
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sfr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [sfr_pkg::DATA_W-1:0] pwdata,
    output logic      [sfr_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,   // [7:0] rx_data
    input  wire logic [1:0]                 s_tuser,   // [1:0] req_type
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [7:0]                 m_tdata,   // [7:0] control_value
    output logic      [1:0]                 m_tuser    // [1:0] status
);

    sfr_pkg::cfg_t cfg;
    sfr_pkg::evt_t q_evt;
    logic          q_valid;
    logic          q_ready;

    sfr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfr_front #(
        .QueueDepth (QueueDepth)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_evt    (q_evt)
    );

    sfr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_evt    (q_evt),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `SFR_ASSERT(a_status_known, !m_tvalid || m_tuser <= sfr_pkg::ST_INVALID, "Bad status.")
    `SFR_ASSERT_IMPL(a_zero_unless_valid, m_tvalid && m_tuser != sfr_pkg::ST_VALID, m_tdata == 8'd0, "Non-frame result carries a control byte.")
    `SFR_ASSERT_IMPL(a_valid_control, m_tvalid && m_tuser == sfr_pkg::ST_VALID, sfr_pkg::control_ok(m_tdata), "Valid frame reports a rejected control byte.")

endmodule

`default_nettype wire

FILE: hw/rtl/sfr_regs.sv
// Configuration register file of the supervisory frame receiver.
`default_nettype none

module sfr_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sfr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [sfr_pkg::DATA_W-1:0] pwdata,
    output logic      [sfr_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output sfr_pkg::cfg_t                   cfg
);

    sfr_pkg::cfg_t cfg_reg;
    sfr_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                sfr_pkg::REG_FLAG:    cfg_next.flag_byte    = pwdata[7:0];
                sfr_pkg::REG_ADDRESS: cfg_next.address_byte = pwdata[7:0];
                sfr_pkg::REG_LENGTH:  cfg_next.frame_length = pwdata[2:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flag_byte    <= sfr_pkg::FLAG_RESET;
            cfg_reg.address_byte <= sfr_pkg::ADDRESS_RESET;
            cfg_reg.frame_length <= sfr_pkg::LENGTH_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_idx)
            sfr_pkg::REG_FLAG:    prdata = {24'd0, cfg_reg.flag_byte};
            sfr_pkg::REG_ADDRESS: prdata = {24'd0, cfg_reg.address_byte};
            sfr_pkg::REG_LENGTH:  prdata = {29'd0, cfg_reg.frame_length};
            default:              prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/sfr_front.sv
// Input side: classifies each request and holds it in a short event queue.
`default_nettype none

module sfr_front #(
    parameter int QueueDepth = sfr_pkg::QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic [1:0] s_tuser,
    output logic            q_valid,
    input  wire logic       q_ready,
    output sfr_pkg::evt_t   q_evt
);

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);
    localparam logic [CntW-1:0] FullCount = CntW'(QueueDepth);
    localparam logic [PtrW-1:0] LastPtr   = PtrW'(QueueDepth - 1);

    sfr_pkg::evt_t   mem [QueueDepth];
    sfr_pkg::evt_t   in_evt;
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            push;
    logic            pop;

    always_comb begin
        in_evt.data = s_tdata;
        case (s_tuser)
            sfr_pkg::REQ_BYTE:    in_evt.kind = sfr_pkg::KIND_BYTE;
            sfr_pkg::REQ_TIMEOUT: in_evt.kind = sfr_pkg::KIND_TIMEOUT;
            default:              in_evt.kind = sfr_pkg::KIND_ERROR;
        endcase
    end

    assign s_tready = (count_reg != FullCount);
    assign q_valid  = (count_reg != '0);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;
    assign q_evt    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_evt;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sfr_back.sv
// Output side: frame parser state machine and the result register.
`default_nettype none

module sfr_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire sfr_pkg::cfg_t cfg,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire sfr_pkg::evt_t q_evt,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,
    output logic [1:0]         m_tuser
);

    sfr_pkg::parse_state_t state_reg, state_next, adv_state;
    logic [7:0] ctrl_reg, ctrl_next;
    logic       valid_reg, valid_next;
    logic [1:0] status_reg, status_next;
    logic [7:0] value_reg, value_next;
    logic       pop;
    logic [7:0] b;
    logic [7:0] bcc;

    assign q_ready = !valid_reg || m_tready;
    assign pop     = q_valid && q_ready;
    assign b       = q_evt.data;
    assign bcc     = ctrl_reg ^ cfg.address_byte;

    always_comb begin
        adv_state = sfr_pkg::PS_IDLE;
        ctrl_next = ctrl_reg;
        case (state_reg)
            sfr_pkg::PS_IDLE: begin
                adv_state = (b == cfg.flag_byte) ? sfr_pkg::PS_FLAG : sfr_pkg::PS_IDLE;
            end
            sfr_pkg::PS_FLAG: begin
                if (b == cfg.address_byte) begin
                    adv_state = sfr_pkg::PS_ADDR;
                end else if (b == cfg.flag_byte) begin
                    adv_state = sfr_pkg::PS_FLAG;
                end
            end
            sfr_pkg::PS_ADDR: begin
                if (b == cfg.flag_byte) begin
                    adv_state = sfr_pkg::PS_FLAG;
                end else begin
                    adv_state = sfr_pkg::PS_CTRL;
                    ctrl_next = b;
                end
            end
            sfr_pkg::PS_CTRL: begin
                if (b == bcc) begin
                    adv_state = sfr_pkg::PS_BCC;
                end else if (b == cfg.flag_byte) begin
                    adv_state = sfr_pkg::PS_FLAG;
                end
            end
            sfr_pkg::PS_BCC: begin
                adv_state = (b == cfg.flag_byte) ? sfr_pkg::PS_CLOSE : sfr_pkg::PS_IDLE;
            end
            default: begin
                adv_state = sfr_pkg::PS_IDLE;
            end
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        valid_next  = m_tready ? 1'b0 : valid_reg;
        status_next = status_reg;
        value_next  = value_reg;
        if (pop) begin
            case (q_evt.kind)
                sfr_pkg::KIND_BYTE: begin
                    state_next = adv_state;
                    if (3'(adv_state) == sfr_pkg::effective_length(cfg.frame_length)) begin
                        state_next = sfr_pkg::PS_IDLE;
                        valid_next = 1'b1;
                        if (sfr_pkg::control_ok(ctrl_reg)) begin
                            status_next = sfr_pkg::ST_VALID;
                            value_next  = ctrl_reg;
                        end else begin
                            status_next = sfr_pkg::ST_INVALID;
                            value_next  = '0;
                        end
                    end
                end
                sfr_pkg::KIND_TIMEOUT: begin
                    state_next  = sfr_pkg::PS_IDLE;
                    valid_next  = 1'b1;
                    status_next = sfr_pkg::ST_NODATA;
                    value_next  = '0;
                end
                default: begin
                    state_next  = sfr_pkg::PS_IDLE;
                    valid_next  = 1'b1;
                    status_next = sfr_pkg::ST_INVALID;
                    value_next  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sfr_pkg::PS_IDLE;
            ctrl_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ctrl_reg  <= (pop && q_evt.kind == sfr_pkg::KIND_BYTE) ? ctrl_next : ctrl_reg;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        value_reg  <= value_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = value_reg;
    assign m_tuser  = status_reg;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the supervisory frame receiver with a predictor.
`default_nettype none

module testbench;

    localparam logic [1:0] REQ_ERROR   = 2'd2;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam logic [7:0] NOTABLE_CTRL [6] = '{sfr_pkg::CTRL_ZERO, sfr_pkg::CTRL_TWO,
                                                8'h01, 8'h04, 8'hFE, 8'hFF};

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] data;
    } line_event_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] ctrl;
    } frame_report_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [7:0]  m_tdata;
    wire  [1:0]  m_tuser;

    line_event_t   pending_events [$];
    frame_report_t expected_reports [$];

    logic [7:0]   cfg_flag = sfr_pkg::FLAG_RESET;
    logic [7:0]   cfg_addr = sfr_pkg::ADDRESS_RESET;
    logic [2:0]   cfg_len = sfr_pkg::LENGTH_RESET;
    sfr_pkg::parse_state_t rx_state = sfr_pkg::PS_IDLE;
    logic [7:0]   rx_ctrl = 8'h00;

    int  src_idle_pct = 25;
    int  snk_idle_pct = 25;
    int  src_gap = 0;
    int  snk_gap = 0;
    int  hold_left = 0;
    bit  long_hold_go = 1'b0;
    int  mismatches = 0;
    longint cycle_count = 0;

    supervisory_frame_receiver_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void frame_parse_step(input line_event_t ev, output bit has_report,
                                             output frame_report_t rep);
        logic [2:0] eff_len;
        has_report = 1'b0;
        rep = '{status: sfr_pkg::ST_VALID, ctrl: 8'h00};
        eff_len = cfg_len;
        if (cfg_len < sfr_pkg::LENGTH_MIN) begin
            eff_len = sfr_pkg::LENGTH_MIN;
        end else if (cfg_len > sfr_pkg::LENGTH_MAX) begin
            eff_len = sfr_pkg::LENGTH_MAX;
        end
        if (ev.req == sfr_pkg::REQ_TIMEOUT) begin
            rx_state = sfr_pkg::PS_IDLE;
            has_report = 1'b1;
            rep.status = sfr_pkg::ST_NODATA;
        end else if (ev.req != sfr_pkg::REQ_BYTE) begin
            rx_state = sfr_pkg::PS_IDLE;
            has_report = 1'b1;
            rep.status = sfr_pkg::ST_INVALID;
        end else begin
            case (rx_state)
                sfr_pkg::PS_IDLE: begin
                    rx_state = (ev.data == cfg_flag) ? sfr_pkg::PS_FLAG : sfr_pkg::PS_IDLE;
                end
                sfr_pkg::PS_FLAG: begin
                    if (ev.data == cfg_addr) rx_state = sfr_pkg::PS_ADDR;
                    else if (ev.data == cfg_flag) rx_state = sfr_pkg::PS_FLAG;
                    else rx_state = sfr_pkg::PS_IDLE;
                end
                sfr_pkg::PS_ADDR: begin
                    if (ev.data == cfg_flag) begin
                        rx_state = sfr_pkg::PS_FLAG;
                    end else begin
                        rx_ctrl = ev.data;
                        rx_state = sfr_pkg::PS_CTRL;
                    end
                end
                sfr_pkg::PS_CTRL: begin
                    if (ev.data == (rx_ctrl ^ cfg_addr)) rx_state = sfr_pkg::PS_BCC;
                    else if (ev.data == cfg_flag) rx_state = sfr_pkg::PS_FLAG;
                    else rx_state = sfr_pkg::PS_IDLE;
                end
                sfr_pkg::PS_BCC: begin
                    rx_state = (ev.data == cfg_flag) ? sfr_pkg::PS_CLOSE : sfr_pkg::PS_IDLE;
                end
                default: begin
                    rx_state = sfr_pkg::PS_IDLE;
                end
            endcase
            if (3'(rx_state) == eff_len) begin
                rx_state = sfr_pkg::PS_IDLE;
                has_report = 1'b1;
                if (rx_ctrl[0] || rx_ctrl == sfr_pkg::CTRL_ZERO ||
                    rx_ctrl == sfr_pkg::CTRL_TWO) begin
                    rep.status = sfr_pkg::ST_VALID;
                    rep.ctrl = rx_ctrl;
                end else begin
                    rep.status = sfr_pkg::ST_INVALID;
                end
            end
        end
    endfunction

    always @(posedge aclk) begin
        line_event_t   taken;
        bit            has_rep;
        frame_report_t rep;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                taken = pending_events.pop_front();
                frame_parse_step(taken, has_rep, rep);
                if (has_rep) expected_reports.push_back(rep);
            end
            if (!(s_tvalid && !s_tready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_events.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if ($urandom_range(0, 99) < src_idle_pct) begin
                    src_gap = $urandom_range(0, 16);
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tuser <= pending_events[0].req;
                    s_tdata <= pending_events[0].data;
                end
            end
        end
    end

    // The long receiver hold is counted here, apart from the random idling.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (long_hold_go) begin
            hold_left <= LONG_HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        frame_report_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Unexpected result transfer: status %0d, control %02h",
                                 m_tuser, m_tdata);
                    end
                end else begin
                    want = expected_reports.pop_front();
                    if (m_tuser !== want.status || m_tdata !== want.ctrl) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Result mismatch: expected %0d %02h, got %0d %02h",
                                     want.status, want.ctrl, m_tuser, m_tdata);
                        end
                    end
                end
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < snk_idle_pct) begin
                snk_gap = $urandom_range(0, 16);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void push_event(input logic [1:0] req, input logic [7:0] data);
        pending_events.push_back('{req: req, data: data});
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'h0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            sfr_pkg::REG_FLAG:    cfg_flag = val;
            sfr_pkg::REG_ADDRESS: cfg_addr = val;
            sfr_pkg::REG_LENGTH:  cfg_len = val[2:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0 || s_tvalid || expected_reports.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    // Mostly well-formed frames with random content, the rest broken frames and noise.
    task automatic queue_line_traffic(input int n_items);
        int pushed;
        int pick;
        int cut;
        logic [7:0] ctrl;
        logic [7:0] frame [$];
        pushed = 0;
        while (pushed < n_items) begin
            pick = $urandom_range(0, 99);
            frame.delete();
            if (pick < 85) begin
                ctrl = ($urandom_range(0, 1) == 0) ? NOTABLE_CTRL[$urandom_range(0, 5)]
                                                   : 8'($urandom_range(0, 255));
                repeat (1 + $urandom_range(0, 1)) frame.push_back(cfg_flag);
                frame.push_back(cfg_addr);
                frame.push_back(ctrl);
                frame.push_back(ctrl ^ cfg_addr);
                frame.push_back(cfg_flag);
                if (pick >= 70) begin
                    cut = $urandom_range(1, frame.size() - 1);
                    while (frame.size() > cut) void'(frame.pop_back());
                end
                foreach (frame[i]) push_event(sfr_pkg::REQ_BYTE, frame[i]);
                pushed += frame.size();
                if (pick >= 70) begin
                    case ($urandom_range(0, 3))
                        0: push_event(sfr_pkg::REQ_BYTE, 8'($urandom_range(0, 255)));
                        1: push_event(sfr_pkg::REQ_TIMEOUT, 8'($urandom_range(0, 255)));
                        2: push_event(REQ_ERROR, 8'($urandom_range(0, 255)));
                        default: push_event(REQ_UNKNOWN, 8'($urandom_range(0, 255)));
                    endcase
                    pushed++;
                end
            end else if (pick < 95) begin
                push_event(sfr_pkg::REQ_BYTE, 8'($urandom_range(0, 255)));
                pushed++;
            end else begin
                push_event(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
                pushed++;
            end
        end
    endtask

    task automatic run_phase(input logic [7:0] flag, input logic [7:0] addr, input logic [2:0] len,
                             input int src_pct, input int snk_pct, input bit long_hold,
                             input int n_items);
        reg_write(sfr_pkg::REG_FLAG, flag);
        reg_write(sfr_pkg::REG_ADDRESS, addr);
        reg_write(sfr_pkg::REG_LENGTH, {5'b0, len});
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        queue_line_traffic(n_items);
        if (long_hold) begin
            long_hold_go <= 1'b1;
            @(posedge aclk);
            long_hold_go <= 1'b0;
        end
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames under the reset settings.
        push_event(sfr_pkg::REQ_BYTE, 8'h7E);
        push_event(sfr_pkg::REQ_BYTE, 8'h7E);
        push_event(sfr_pkg::REQ_BYTE, 8'h03);
        push_event(sfr_pkg::REQ_BYTE, 8'h01);
        push_event(sfr_pkg::REQ_BYTE, 8'h02);
        push_event(sfr_pkg::REQ_BYTE, 8'h7E);
        push_event(sfr_pkg::REQ_BYTE, 8'h7E);
        push_event(sfr_pkg::REQ_BYTE, 8'h03);
        push_event(sfr_pkg::REQ_BYTE, 8'h7E);
        push_event(sfr_pkg::REQ_BYTE, 8'h03);
        push_event(sfr_pkg::REQ_BYTE, sfr_pkg::CTRL_ZERO);
        push_event(sfr_pkg::REQ_BYTE, 8'h03);
        push_event(sfr_pkg::REQ_BYTE, 8'h7E);
        push_event(sfr_pkg::REQ_BYTE, 8'h7E);
        push_event(sfr_pkg::REQ_BYTE, 8'h03);
        push_event(sfr_pkg::REQ_BYTE, 8'h04);
        push_event(sfr_pkg::REQ_BYTE, 8'h07);
        push_event(sfr_pkg::REQ_BYTE, 8'h7E);
        push_event(sfr_pkg::REQ_BYTE, 8'h7E);
        push_event(sfr_pkg::REQ_BYTE, 8'h03);
        push_event(sfr_pkg::REQ_TIMEOUT, 8'h00);
        push_event(REQ_ERROR, 8'hFF);
        push_event(REQ_UNKNOWN, 8'hFF);
        push_event(sfr_pkg::REQ_BYTE, 8'hFF);
        wait_drained();

        run_phase(8'h00, 8'hFF, 3'd4, 30, 30, 1'b0, 105);
        run_phase(8'hFF, 8'h00, 3'd0, 20, 40, 1'b1, 105);
        run_phase(8'h7E, 8'h03, 3'd7, 0, 0, 1'b0, 105);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 3'd3, 40, 10, 1'b0, 105);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 3'd6, 10, 40, 1'b0, 105);
        run_phase(8'h7E, 8'h03, 3'd5, 0, 0, 1'b0, 105);

        repeat (10) @(posedge aclk);
        if (expected_reports.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
